// ===== hdl/timed_packet_retention_ring_unit_assert.svh =====
// assertion macros for the packet retention ring
`ifndef TIMED_PACKET_RETENTION_RING_UNIT_ASSERT_SVH
`define TIMED_PACKET_RETENTION_RING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TRPR_ASSERT_NOW(lbl, clk, rst_n, cond, rule) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rule)) \
        else $error("trpr check failed");
`define TRPR_ASSERT_NEXT(lbl, clk, rst_n, cond, rule) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (rule)) \
        else $error("trpr check failed");
`else
`define TRPR_ASSERT_NOW(lbl, clk, rst_n, cond, rule)
`define TRPR_ASSERT_NEXT(lbl, clk, rst_n, cond, rule)
`endif

`endif

// ===== hdl/trpr_pkg.sv =====
`timescale 1ns / 1ps
package trpr_pkg;
    localparam int ENTRY_DEPTH = 64;
    localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int CW = $clog2(ENTRY_DEPTH + 1);
    localparam int PTS_W = 63;
    localparam int SIZE_W = 21;
    localparam int WORD_W = 32;
    localparam int TAG_W = 16;
    localparam int OFFSET_W = 62;
    localparam int TOTAL_W = 33;
    localparam int CFG_DATA_W = 62;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W = 2;
    localparam int CODEC_CONFIG_BIT = 1;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SESSION_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PTS_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETENTION  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES  = 2'd3;

    localparam logic [WORD_W-1:0] RETENTION_RESET = 32'd72_000_000;
    localparam logic [WORD_W-1:0] MAX_BYTES_RESET = 32'd4194304;
    localparam logic [PTS_W-1:0]  PTS_MAX = {PTS_W{1'b1}};

    typedef struct packed {
        logic [PTS_W-1:0]  pts;
        logic [WORD_W-1:0] flags;
        logic [SIZE_W-1:0] size;
        logic [WORD_W-1:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PTS_W-1:0]  pts;
        logic [WORD_W-1:0] flags;
        logic [WORD_W-1:0] handle;
        logic              last;
    } t_out_req;

    typedef struct packed {
        logic [WORD_W-1:0]  codec_handle;
        logic               config_present;
        logic [CW-1:0]      count;
        logic [PTS_W-1:0]   newest_pts;
        logic [PTS_W-1:0]   oldest_pts;
        logic [TOTAL_W-1:0] total;
    } t_status;

    // ring index plus offset, wrapped at the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW+1)'(ENTRY_DEPTH)) begin
            sum = sum - (CW+1)'(ENTRY_DEPTH);
        end
        return sum[AW-1:0];
    endfunction
endpackage

// ===== hdl/timed_packet_retention_ring_unit.sv =====
`timescale 1ns / 1ps
// packet retention ring: keeps up to 64 packet descriptors in arrival order
// input channel (i_in_valid / o_in_ready): one item is an append (operation 0)
// or a range query (operation 1); only one item is in work at a time
// output channel (o_out_valid / i_out_ready): an append gives one status item,
// a query gives one frame item per held descriptor in range, one empty item
// when no codec config or no frame is held, or nothing when none matches
// sequence: an append goes through decide and the adjust states, a read and
// eviction of the oldest entry when the ring is full, the push, then a memory
// read and check of the oldest entry, repeated while it is evicted, before its
// status item; a dropped append or an empty answer goes from decide straight to
// status; a query reads and checks each held entry in turn
// configuration: i_cfg_we writes register i_cfg_index at once; the user must
// write only while idle, and the block itself does not enforce this; reset
// clears count, byte total, ring pointer and codec config; registers go to their
// defaults; the descriptor memory is not cleared, only written entries are read
// a stalled receiver holds the output register; the sequencer waits for it
// before loading the next item, so nothing is lost or repeated
`include "timed_packet_retention_ring_unit_assert.svh"
module timed_packet_retention_ring_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [trpr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [trpr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [trpr_pkg::TAG_W-1:0]           i_session_tag,
    input  logic signed [63:0]                   i_packet_pts,
    input  logic [trpr_pkg::SIZE_W-1:0]          i_payload_bytes,
    input  logic [trpr_pkg::WORD_W-1:0]          i_packet_flags,
    input  logic [trpr_pkg::WORD_W-1:0]          i_payload_handle,
    input  logic signed [63:0]                   i_range_from,
    input  logic signed [63:0]                   i_range_to,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [trpr_pkg::KIND_W-1:0]          o_item_kind,
    output logic [trpr_pkg::PTS_W-1:0]           o_frame_pts,
    output logic [trpr_pkg::WORD_W-1:0]          o_frame_flags,
    output logic [trpr_pkg::WORD_W-1:0]          o_frame_handle,
    output logic [trpr_pkg::WORD_W-1:0]          o_codec_handle,
    output logic                                 o_last_of_run,
    output logic                                 o_available,
    output logic [trpr_pkg::CW-1:0]              o_packet_count,
    output logic [trpr_pkg::PTS_W-1:0]           o_span_us,
    output logic [trpr_pkg::WORD_W-1:0]          o_held_bytes
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_ADJ1, ST_ADJ2, ST_FULL_RD, ST_FULL_EV, ST_PUSH,
        ST_EV_RD, ST_EV_CHK, ST_STATUS, ST_Q_RD, ST_Q_CHK, ST_Q_LAST
    } t_state;

    t_state r_state;

    // configuration registers
    logic [trpr_pkg::TAG_W-1:0]    r_session_id;
    logic [trpr_pkg::OFFSET_W-1:0] r_pts_offset;
    logic [trpr_pkg::WORD_W-1:0]   r_retention;
    logic [trpr_pkg::WORD_W-1:0]   r_max_bytes;

    // captured input item
    logic                          r_op;
    logic [trpr_pkg::TAG_W-1:0]    r_tag;
    logic signed [63:0]            r_pts;
    logic [trpr_pkg::SIZE_W-1:0]   r_bytes;
    logic [trpr_pkg::WORD_W-1:0]   r_flags;
    logic [trpr_pkg::WORD_W-1:0]   r_handle;
    logic signed [63:0]            r_from;
    logic signed [63:0]            r_to;

    // ring bookkeeping
    logic [trpr_pkg::AW-1:0]       r_oldest;
    logic [trpr_pkg::CW-1:0]       r_count;
    logic [trpr_pkg::TOTAL_W-1:0]  r_total;
    logic                          r_cfg_present;
    logic [trpr_pkg::WORD_W-1:0]   r_cfg_handle;
    logic [trpr_pkg::PTS_W-1:0]    r_newest_pts;
    logic [trpr_pkg::PTS_W-1:0]    r_oldest_pts;

    // work registers
    logic [trpr_pkg::PTS_W-1:0]    r_adj;
    logic signed [63:0]            r_cutoff;
    logic [trpr_pkg::KIND_W-1:0]   r_kind;
    logic [trpr_pkg::CW-1:0]       r_k;
    logic                          r_have_pend;
    trpr_pkg::t_entry              r_pend;

    // memory port
    logic                          ram_we;
    logic [trpr_pkg::AW-1:0]       ram_waddr;
    trpr_pkg::t_entry              ram_wdata;
    logic                          ram_re;
    logic [trpr_pkg::AW-1:0]       ram_raddr;
    trpr_pkg::t_entry              ram_rdata;

    // output stage
    logic                          out_load;
    logic                          out_free;
    trpr_pkg::t_out_req            out_req;
    trpr_pkg::t_status             status;

    logic signed [63:0]            diff;
    logic signed [63:0]            rd_pts_s;
    logic                          hit;
    logic                          evict_more;

    trpr_ram #(
        .WIDTH(trpr_pkg::ENTRY_W),
        .DEPTH(trpr_pkg::ENTRY_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign status.codec_handle   = r_cfg_handle;
    assign status.config_present = r_cfg_present;
    assign status.count          = r_count;
    assign status.newest_pts     = r_newest_pts;
    assign status.oldest_pts     = r_oldest_pts;
    assign status.total          = r_total;

    trpr_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_req         (out_req),
        .i_status      (status),
        .o_free        (out_free),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_item_kind   (o_item_kind),
        .o_frame_pts   (o_frame_pts),
        .o_frame_flags (o_frame_flags),
        .o_frame_handle(o_frame_handle),
        .o_codec_handle(o_codec_handle),
        .o_last_of_run (o_last_of_run),
        .o_available   (o_available),
        .o_packet_count(o_packet_count),
        .o_span_us     (o_span_us),
        .o_held_bytes  (o_held_bytes)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    // offset-shifted timestamp; raw is positive here so this cannot overflow
    assign diff     = r_pts - $signed({2'b00, r_pts_offset});
    assign rd_pts_s = $signed({1'b0, ram_rdata.pts});
    assign hit      = (rd_pts_s >= r_from) && (rd_pts_s <= r_to);
    assign evict_more = (r_count > trpr_pkg::CW'(1)) &&
                        ((rd_pts_s < r_cutoff) || (r_total > {1'b0, r_max_bytes}));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = trpr_pkg::wrap_add(r_oldest, r_count);
        ram_wdata = '{pts: r_adj, flags: r_flags, size: r_bytes, handle: r_handle};
        ram_re    = 1'b0;
        ram_raddr = r_oldest;
        out_load  = 1'b0;
        out_req   = '{kind: r_kind, pts: '0, flags: '0, handle: '0, last: 1'b1};
        case (r_state)
            ST_FULL_RD, ST_EV_RD: begin
                ram_re = 1'b1;
            end
            ST_PUSH: begin
                ram_we = 1'b1;
            end
            ST_Q_RD: begin
                ram_re    = 1'b1;
                ram_raddr = trpr_pkg::wrap_add(r_oldest, r_k);
            end
            ST_STATUS: begin
                out_load = out_free;
            end
            ST_Q_CHK, ST_Q_LAST: begin
                // a held hit goes out once the next hit or the end of the walk is known
                out_load = r_have_pend && out_free && (hit || (r_state == ST_Q_LAST));
                out_req  = '{kind: trpr_pkg::KIND_FRAME, pts: r_pend.pts,
                             flags: r_pend.flags, handle: r_pend.handle,
                             last: (r_state == ST_Q_LAST)};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_session_id  <= '0;
            r_pts_offset  <= '0;
            r_retention   <= trpr_pkg::RETENTION_RESET;
            r_max_bytes   <= trpr_pkg::MAX_BYTES_RESET;
            r_oldest      <= '0;
            r_count       <= '0;
            r_total       <= '0;
            r_cfg_present <= 1'b0;
            r_cfg_handle  <= '0;
            r_have_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    trpr_pkg::REG_SESSION_ID: r_session_id <= i_cfg_data[trpr_pkg::TAG_W-1:0];
                    trpr_pkg::REG_PTS_OFFSET: r_pts_offset <= i_cfg_data;
                    trpr_pkg::REG_RETENTION:  r_retention  <= i_cfg_data[trpr_pkg::WORD_W-1:0];
                    trpr_pkg::REG_MAX_BYTES:  r_max_bytes  <= i_cfg_data[trpr_pkg::WORD_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_operation;
                        r_tag    <= i_session_tag;
                        r_pts    <= i_packet_pts;
                        r_bytes  <= i_payload_bytes;
                        r_flags  <= i_packet_flags;
                        r_handle <= i_payload_handle;
                        r_from   <= i_range_from;
                        r_to     <= i_range_to;
                        r_state  <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    // a query without config or frames answers with one empty item
                    r_kind <= (r_op && (!r_cfg_present || (r_count == '0)))
                              ? trpr_pkg::KIND_EMPTY : trpr_pkg::KIND_STATUS;
                    r_k    <= '0;
                    if (r_op) begin
                        if (!r_cfg_present || (r_count == '0)) begin
                            r_state <= ST_STATUS;
                        end else begin
                            r_have_pend <= 1'b0;
                            r_state     <= ST_Q_RD;
                        end
                    end else if (r_tag != r_session_id) begin
                        r_state <= ST_STATUS;
                    end else if (r_flags[trpr_pkg::CODEC_CONFIG_BIT]) begin
                        r_cfg_present <= 1'b1;
                        r_cfg_handle  <= r_handle;
                        r_state       <= ST_STATUS;
                    end else if (r_pts[63] || (r_pts == '0)) begin
                        r_state <= ST_STATUS;
                    end else begin
                        r_state <= ST_ADJ1;
                    end
                end
                ST_ADJ1: begin
                    // clamp to at least 1
                    r_adj   <= (diff[63] || (diff == '0)) ? trpr_pkg::PTS_W'(1)
                                                          : diff[trpr_pkg::PTS_W-1:0];
                    r_state <= ST_ADJ2;
                end
                ST_ADJ2: begin
                    // strictly rising, held at the ceiling
                    if ((r_count != '0) && (r_adj <= r_newest_pts)) begin
                        r_adj <= (r_newest_pts != trpr_pkg::PTS_MAX) ? r_newest_pts + 1'b1
                                                                    : r_newest_pts;
                    end
                    r_state <= (r_count == trpr_pkg::CW'(trpr_pkg::ENTRY_DEPTH)) ? ST_FULL_RD
                                                                                : ST_PUSH;
                end
                ST_FULL_RD: begin
                    r_state <= ST_FULL_EV;
                end
                ST_FULL_EV: begin
                    r_total  <= r_total - trpr_pkg::TOTAL_W'(ram_rdata.size);
                    r_oldest <= trpr_pkg::wrap_add(r_oldest, trpr_pkg::CW'(1));
                    r_count  <= r_count - 1'b1;
                    r_state  <= ST_PUSH;
                end
                ST_PUSH: begin
                    r_count      <= r_count + 1'b1;
                    r_total      <= r_total + trpr_pkg::TOTAL_W'(r_bytes);
                    r_newest_pts <= r_adj;
                    r_cutoff     <= $signed({1'b0, r_adj}) - $signed({32'd0, r_retention});
                    r_state      <= ST_EV_RD;
                end
                ST_EV_RD: begin
                    r_state <= ST_EV_CHK;
                end
                ST_EV_CHK: begin
                    if (evict_more) begin
                        r_total  <= r_total - trpr_pkg::TOTAL_W'(ram_rdata.size);
                        r_oldest <= trpr_pkg::wrap_add(r_oldest, trpr_pkg::CW'(1));
                        r_count  <= r_count - 1'b1;
                        r_state  <= ST_EV_RD;
                    end else begin
                        r_oldest_pts <= ram_rdata.pts;
                        r_state      <= ST_STATUS;
                    end
                end
                ST_STATUS: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_Q_RD: begin
                    r_state <= ST_Q_CHK;
                end
                ST_Q_CHK: begin
                    // the read data holds while waiting for the output register
                    if (!hit || !r_have_pend || out_free) begin
                        if (hit) begin
                            r_pend      <= ram_rdata;
                            r_have_pend <= 1'b1;
                        end
                        r_k     <= r_k + 1'b1;
                        r_state <= (r_k + 1'b1 == r_count) ? ST_Q_LAST : ST_Q_RD;
                    end
                end
                ST_Q_LAST: begin
                    if (!r_have_pend || out_free) begin
                        r_have_pend <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // the ring never holds more than its depth
    `TRPR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= trpr_pkg::CW'(trpr_pkg::ENTRY_DEPTH))
    // after a push at least one entry is held
    `TRPR_ASSERT_NEXT(a_push_nonempty, i_clk, i_rst_n, r_state == ST_PUSH, r_count != '0)
    // frame items only come from a ring with config and frames
    `TRPR_ASSERT_NOW(a_frame_avail, i_clk, i_rst_n, o_out_valid && (o_item_kind == trpr_pkg::KIND_FRAME), o_available)
endmodule

// ===== hdl/trpr_ram.sv =====
`timescale 1ns / 1ps
module trpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [WIDTH-1:0]             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/trpr_out.sv =====
`timescale 1ns / 1ps
module trpr_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  trpr_pkg::t_out_req              i_req,
    input  trpr_pkg::t_status               i_status,
    output logic                            o_free,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [trpr_pkg::KIND_W-1:0]     o_item_kind,
    output logic [trpr_pkg::PTS_W-1:0]      o_frame_pts,
    output logic [trpr_pkg::WORD_W-1:0]     o_frame_flags,
    output logic [trpr_pkg::WORD_W-1:0]     o_frame_handle,
    output logic [trpr_pkg::WORD_W-1:0]     o_codec_handle,
    output logic                            o_last_of_run,
    output logic                            o_available,
    output logic [trpr_pkg::CW-1:0]         o_packet_count,
    output logic [trpr_pkg::PTS_W-1:0]      o_span_us,
    output logic [trpr_pkg::WORD_W-1:0]     o_held_bytes
);
    logic                        r_valid;
    trpr_pkg::t_out_req          r_req;
    logic [trpr_pkg::WORD_W-1:0] r_codec;
    logic                        r_avail;
    logic [trpr_pkg::CW-1:0]     r_count;
    logic [trpr_pkg::PTS_W-1:0]  r_span;
    logic [trpr_pkg::WORD_W-1:0] r_bytes;
    logic                        nonempty;

    assign o_free   = !r_valid || i_ready;
    assign nonempty = (i_status.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_req   <= i_req;
            r_codec <= i_status.codec_handle;
            r_avail <= i_status.config_present && nonempty;
            r_count <= i_status.count;
            r_span  <= nonempty ? (i_status.newest_pts - i_status.oldest_pts) : '0;
            // saturate the byte total to the port width
            r_bytes <= i_status.total[trpr_pkg::TOTAL_W-1] ? {trpr_pkg::WORD_W{1'b1}}
                                                           : i_status.total[trpr_pkg::WORD_W-1:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_item_kind    = r_req.kind;
    assign o_frame_pts    = r_req.pts;
    assign o_frame_flags  = r_req.flags;
    assign o_frame_handle = r_req.handle;
    assign o_last_of_run  = r_req.last;
    assign o_codec_handle = r_codec;
    assign o_available    = r_avail;
    assign o_packet_count = r_count;
    assign o_span_us      = r_span;
    assign o_held_bytes   = r_bytes;
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    localparam int RING_DEPTH = trpr_pkg::ENTRY_DEPTH;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [trpr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [trpr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_operation;
    logic [trpr_pkg::TAG_W-1:0]      i_session_tag;
    logic signed [63:0]              i_packet_pts;
    logic [trpr_pkg::SIZE_W-1:0]     i_payload_bytes;
    logic [trpr_pkg::WORD_W-1:0]     i_packet_flags;
    logic [trpr_pkg::WORD_W-1:0]     i_payload_handle;
    logic signed [63:0]              i_range_from;
    logic signed [63:0]              i_range_to;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [trpr_pkg::KIND_W-1:0]     o_item_kind;
    logic [trpr_pkg::PTS_W-1:0]      o_frame_pts;
    logic [trpr_pkg::WORD_W-1:0]     o_frame_flags;
    logic [trpr_pkg::WORD_W-1:0]     o_frame_handle;
    logic [trpr_pkg::WORD_W-1:0]     o_codec_handle;
    logic                            o_last_of_run;
    logic                            o_available;
    logic [trpr_pkg::CW-1:0]         o_packet_count;
    logic [trpr_pkg::PTS_W-1:0]      o_span_us;
    logic [trpr_pkg::WORD_W-1:0]     o_held_bytes;

    timed_packet_retention_ring_unit dut (.*);

    // one expected output item
    typedef struct {
        logic [trpr_pkg::KIND_W-1:0] kind;
        logic [trpr_pkg::PTS_W-1:0]  pts;
        logic [trpr_pkg::WORD_W-1:0] flags;
        logic [trpr_pkg::WORD_W-1:0] handle;
        logic [trpr_pkg::WORD_W-1:0] codec;
        logic                        last;
        logic                        avail;
        logic [trpr_pkg::CW-1:0]     count;
        logic [trpr_pkg::PTS_W-1:0]  span;
        logic [trpr_pkg::WORD_W-1:0] bytes;
    } t_result;

    t_result pending_results[$];

    // shadow of the ring
    logic [trpr_pkg::TAG_W-1:0]    sh_session;
    logic [trpr_pkg::OFFSET_W-1:0] sh_offset;
    logic [trpr_pkg::WORD_W-1:0]   sh_retention;
    logic [trpr_pkg::WORD_W-1:0]   sh_max_bytes;
    logic [trpr_pkg::PTS_W-1:0]    ring_pts[RING_DEPTH];
    logic [trpr_pkg::WORD_W-1:0]   ring_flags[RING_DEPTH];
    logic [trpr_pkg::SIZE_W-1:0]   ring_size[RING_DEPTH];
    logic [trpr_pkg::WORD_W-1:0]   ring_handle[RING_DEPTH];
    int                            ring_head;
    int                            ring_count;
    logic [trpr_pkg::TOTAL_W:0]    ring_bytes;
    logic                          codec_held;
    logic [trpr_pkg::WORD_W-1:0]   codec_ref;

    int   error_count;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    function automatic int slot(int k);
        return (ring_head + k) % RING_DEPTH;
    endfunction

    function automatic void queue_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic t_result snapshot(logic [trpr_pkg::KIND_W-1:0] kind, int s,
                                         bit is_frame, bit last);
        t_result r;
        r.kind   = kind;
        r.pts    = is_frame ? ring_pts[s] : '0;
        r.flags  = is_frame ? ring_flags[s] : '0;
        r.handle = is_frame ? ring_handle[s] : '0;
        r.codec  = codec_ref;
        r.last   = last;
        r.avail  = codec_held && ring_count > 0;
        r.count  = trpr_pkg::CW'(ring_count);
        r.span   = ring_count > 0 ? ring_pts[slot(ring_count - 1)] - ring_pts[ring_head]
                                  : '0;
        r.bytes  = ring_bytes > {1'b0, 33'hFFFFFFFF} ? 32'hFFFFFFFF : ring_bytes[31:0];
        return r;
    endfunction

    function automatic void drop_oldest();
        ring_bytes = ring_bytes - ring_size[ring_head];
        ring_head  = (ring_head + 1) % RING_DEPTH;
        ring_count--;
    endfunction

    function automatic void store_packet(logic [trpr_pkg::TAG_W-1:0] tag,
                                         logic signed [63:0] pts,
                                         logic [trpr_pkg::SIZE_W-1:0] nbytes,
                                         logic [trpr_pkg::WORD_W-1:0] flg,
                                         logic [trpr_pkg::WORD_W-1:0] hnd);
        logic signed [64:0]          adj;
        logic signed [64:0]          cutoff;
        logic [trpr_pkg::PTS_W-1:0]  newest;
        int                          s;
        if (tag != sh_session) return;
        if (flg[trpr_pkg::CODEC_CONFIG_BIT]) begin
            codec_held = 1'b1;
            codec_ref  = hnd;
            return;
        end
        if (pts <= 0) return;
        adj = 65'(pts) - $signed({3'b0, sh_offset});
        if (adj < 1) adj = 1;
        if (ring_count > 0) begin
            newest = ring_pts[slot(ring_count - 1)];
            if (adj <= $signed({2'b0, newest}))
                adj = (newest != trpr_pkg::PTS_MAX) ? $signed({2'b0, newest}) + 1
                                                    : $signed({2'b0, newest});
        end
        if (ring_count >= RING_DEPTH) drop_oldest();
        s = slot(ring_count);
        ring_pts[s]    = adj[trpr_pkg::PTS_W-1:0];
        ring_flags[s]  = flg;
        ring_size[s]   = nbytes;
        ring_handle[s] = hnd;
        ring_count++;
        ring_bytes = ring_bytes + nbytes;
        cutoff = adj - $signed({33'b0, sh_retention});
        while (ring_count > 1 &&
               ($signed({2'b0, ring_pts[ring_head]}) < cutoff ||
                ring_bytes > {2'b0, sh_max_bytes}))
            drop_oldest();
    endfunction

    // works out all result items caused by one accepted item
    function automatic void predict_ring(logic op, logic [trpr_pkg::TAG_W-1:0] tag,
                                         logic signed [63:0] pts,
                                         logic [trpr_pkg::SIZE_W-1:0] nbytes,
                                         logic [trpr_pkg::WORD_W-1:0] flg,
                                         logic [trpr_pkg::WORD_W-1:0] hnd,
                                         logic signed [63:0] lo, logic signed [63:0] hi);
        int hits[$];
        logic signed [63:0] p;
        if (!op) begin
            store_packet(tag, pts, nbytes, flg, hnd);
            queue_result(snapshot(trpr_pkg::KIND_STATUS, 0, 0, 1));
            return;
        end
        if (!codec_held || ring_count == 0) begin
            queue_result(snapshot(trpr_pkg::KIND_EMPTY, 0, 0, 1));
            return;
        end
        for (int k = 0; k < ring_count; k++) begin
            p = $signed({1'b0, ring_pts[slot(k)]});
            if (p >= lo && p <= hi) hits.insert(hits.size(), slot(k));
        end
        foreach (hits[k])
            queue_result(snapshot(trpr_pkg::KIND_FRAME, hits[k], 1, k == hits.size() - 1));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timed_packet_retention_ring_unit verification failed");
        $finish;
    end

    // receiver: random stall, compare each accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) $display("unexpected item kind %0d", o_item_kind);
                end else begin
                    t_result e;
                    e = pending_results[0];
                    pending_results.delete(0);
                    if (e.kind !== o_item_kind || e.pts !== o_frame_pts ||
                        e.flags !== o_frame_flags || e.handle !== o_frame_handle ||
                        e.codec !== o_codec_handle || e.last !== o_last_of_run ||
                        e.avail !== o_available || e.count !== o_packet_count ||
                        e.span !== o_span_us || e.bytes !== o_held_bytes) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("mismatch exp k%0d pts%0h f%0h h%0h c%0h l%0b a%0b n%0d s%0h b%0h",
                                     e.kind, e.pts, e.flags, e.handle, e.codec, e.last,
                                     e.avail, e.count, e.span, e.bytes);
                            $display("         got k%0d pts%0h f%0h h%0h c%0h l%0b a%0b n%0d s%0h b%0h",
                                     o_item_kind, o_frame_pts, o_frame_flags, o_frame_handle,
                                     o_codec_handle, o_last_of_run, o_available,
                                     o_packet_count, o_span_us, o_held_bytes);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // sends one item, with random idle cycles before it
    task automatic send_item(logic op, logic [trpr_pkg::TAG_W-1:0] tag,
                             logic signed [63:0] pts, logic [trpr_pkg::SIZE_W-1:0] nbytes,
                             logic [trpr_pkg::WORD_W-1:0] flg,
                             logic [trpr_pkg::WORD_W-1:0] hnd, logic signed [63:0] lo,
                             logic signed [63:0] hi);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_session_tag    <= tag;
        i_packet_pts     <= pts;
        i_payload_bytes  <= nbytes;
        i_packet_flags   <= flg;
        i_payload_handle <= hnd;
        i_range_from     <= lo;
        i_range_to       <= hi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_ring(op, tag, pts, nbytes, flg, hnd, lo, hi);
    endtask

    task automatic append_packet(logic [trpr_pkg::TAG_W-1:0] tag, logic signed [63:0] pts,
                                 logic [trpr_pkg::SIZE_W-1:0] nbytes,
                                 logic [trpr_pkg::WORD_W-1:0] flg,
                                 logic [trpr_pkg::WORD_W-1:0] hnd);
        send_item(1'b0, tag, pts, nbytes, flg, hnd, $signed(64'($urandom)),
                  $signed(64'($urandom)));
    endtask

    task automatic query_range(logic signed [63:0] lo, logic signed [63:0] hi);
        send_item(1'b1, trpr_pkg::TAG_W'($urandom), $signed({$urandom, $urandom}),
                  trpr_pkg::SIZE_W'($urandom), $urandom, $urandom, lo, hi);
    endtask

    // drain and let eviction finish, ahead of a register write
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [trpr_pkg::CFG_IDX_W-1:0] idx,
                             logic [trpr_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            trpr_pkg::REG_SESSION_ID: sh_session   = val[trpr_pkg::TAG_W-1:0];
            trpr_pkg::REG_PTS_OFFSET: sh_offset    = val[trpr_pkg::OFFSET_W-1:0];
            trpr_pkg::REG_RETENTION:  sh_retention = val[trpr_pkg::WORD_W-1:0];
            default:                  sh_max_bytes = val[trpr_pkg::WORD_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    // extremes, codec config, drops, empty and no-match queries, ceiling
    task automatic test_directed();
        query_range(64'sh8000000000000000, 64'sh7FFFFFFFFFFFFFFF);
        append_packet(16'h0000, 64'sd1000, 21'd1, 32'h0, 32'h11);
        query_range(64'sh8000000000000000, 64'sh7FFFFFFFFFFFFFFF);
        append_packet(16'hFFFF, 64'sd500, 21'd10, 32'h0, 32'h22);
        append_packet(16'h0000, 64'sd0, 21'd10, 32'h2, 32'hC0DEC0DE);
        append_packet(16'h0000, 64'sh8000000000000000, 21'h1FFFFF, 32'hFFFFFFFD, 32'hFFFFFFFF);
        append_packet(16'h0000, 64'sd0, 21'd5, 32'h0, 32'h33);
        append_packet(16'h0000, 64'sd900, 21'd5, 32'hFFFFFFFD, 32'h44);
        append_packet(16'h0000, 64'sd1, 21'd1048576, 32'h1, 32'h55);
        query_range(64'sh8000000000000000, 64'sh7FFFFFFFFFFFFFFF);
        query_range(64'sd5000, 64'sd4000);
        append_packet(16'h0000, 64'sh7FFFFFFFFFFFFFFF, 21'd7, 32'h0, 32'h66);
        append_packet(16'h0000, 64'sh7FFFFFFFFFFFFFFF, 21'd7, 32'h0, 32'h77);
        append_packet(16'h0000, 64'sd2, 21'h1FFFFF, 32'h0, 32'h88);
        query_range(64'sh7FFFFFFFFFFFFFF0, 64'sh7FFFFFFFFFFFFFFF);
        query_range(64'sd1, 64'sd1);
    endtask

    // time-rising appends with occasional queries and noise
    task automatic test_random_traffic(int n_items);
        logic signed [63:0]         clock_us;
        int                         pick;
        logic [trpr_pkg::TAG_W-1:0] tag;
        logic signed [63:0]         a;
        logic signed [63:0]         b;
        clock_us = 64'sd1000 + $urandom_range(5000);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            tag  = ($urandom_range(9) == 0) ? trpr_pkg::TAG_W'($urandom) : sh_session;
            if (pick < 60) begin
                clock_us = clock_us + $urandom_range(40000);
                append_packet(tag, clock_us, trpr_pkg::SIZE_W'($urandom_range(1, 200000)),
                              $urandom & ~32'h2, $urandom);
            end else if (pick < 66) begin
                append_packet(tag, $signed({$urandom, $urandom}), trpr_pkg::SIZE_W'($urandom),
                              $urandom, $urandom);
            end else if (pick < 70) begin
                append_packet(tag, $signed(64'($urandom)), trpr_pkg::SIZE_W'($urandom),
                              $urandom | 32'h2, $urandom);
            end else if (pick < 90) begin
                a = clock_us - $urandom_range(400000);
                b = a + $urandom_range(400000);
                query_range(a, b);
            end else begin
                a = $signed({$urandom, $urandom});
                b = $signed({$urandom, $urandom});
                query_range(a, b);
            end
        end
    endtask

    initial begin
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        sh_session   = '0;
        sh_offset    = '0;
        sh_retention = trpr_pkg::RETENTION_RESET;
        sh_max_bytes = trpr_pkg::MAX_BYTES_RESET;
        ring_head  = 0;
        ring_count = 0;
        ring_bytes = '0;
        codec_held = 1'b0;
        codec_ref  = '0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_operation      = 1'b0;
        i_session_tag    = '0;
        i_packet_pts     = '0;
        i_payload_bytes  = '0;
        i_packet_flags   = '0;
        i_payload_handle = '0;
        i_range_from     = '0;
        i_range_to       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();

        // tight limits, small offset
        write_reg(trpr_pkg::REG_SESSION_ID, 62'h0000FFFF);
        write_reg(trpr_pkg::REG_PTS_OFFSET, 62'd500);
        write_reg(trpr_pkg::REG_RETENTION, 62'd1);
        write_reg(trpr_pkg::REG_MAX_BYTES, 62'd1);
        test_random_traffic(40);
        wait_drained();

        // wide limits, deep ring
        write_reg(trpr_pkg::REG_SESSION_ID, 62'h00001234);
        write_reg(trpr_pkg::REG_PTS_OFFSET, 62'd0);
        write_reg(trpr_pkg::REG_RETENTION, 62'hFFFFFFFF);
        write_reg(trpr_pkg::REG_MAX_BYTES, 62'hFFFFFFFF);
        sender_idle_pct = 83;
        test_random_traffic(80);
        wait_drained();

        // huge offset clamps the time-rising timestamps to the floor
        write_reg(trpr_pkg::REG_PTS_OFFSET, 62'h3FFFFFFFFFFFFFFF);
        write_reg(trpr_pkg::REG_RETENTION, 62'd72000000);
        write_reg(trpr_pkg::REG_MAX_BYTES, 62'd4194304);
        sender_idle_pct    = 0;
        receiver_stall_pct = 83;
        test_random_traffic(60);
        wait_drained();

        write_reg(trpr_pkg::REG_PTS_OFFSET, 62'd2000);
        write_reg(trpr_pkg::REG_RETENTION, 62'd150000);
        write_reg(trpr_pkg::REG_MAX_BYTES, 62'd1500000);
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        test_random_traffic(60);
        wait_drained();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_traffic(70);

        wait_drained();
        if (error_count == 0)
            $display("timed_packet_retention_ring_unit verification clean");
        else
            $display("timed_packet_retention_ring_unit verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/trpr_pkg.sv
hdl/trpr_ram.sv
hdl/trpr_out.sv
hdl/timed_packet_retention_ring_unit.sv
tb/sv/tb_top.sv
